// File: hw/rtl/s5rp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s5rp_pkg
// Types, codes and constants shared by the SOCKS5 request parser.
// ----------------------------------------------------------------------------
package s5rp_pkg;

   // parser phase codes
   typedef enum logic [2:0] {
      PH_VER  = 3'd0,
      PH_CMD  = 3'd1,
      PH_RSV  = 3'd2,
      PH_ATYP = 3'd3,
      PH_ADDR = 3'd4,
      PH_PORT = 3'd5,
      PH_DONE = 3'd6,
      PH_ERR  = 3'd7
   } phase_type;

   // what each word was taken as
   typedef enum logic [2:0] {
      FK_VER  = 3'd0,
      FK_CMD  = 3'd1,
      FK_RSV  = 3'd2,
      FK_ATYP = 3'd3,
      FK_DLEN = 3'd4,
      FK_ADDR = 3'd5,
      FK_PORT = 3'd6,
      FK_IGN  = 3'd7
   } field_kind_type;

   // status codes
   localparam logic [1:0] ST_BUSY     = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_ERROR    = 2'd2;

   // protocol constants
   localparam logic [7:0] SOCKS_VERSION = 8'd5;
   localparam logic [7:0] CMD_CONNECT   = 8'd1;
   localparam logic [7:0] CMD_UDP_ASSOC = 8'd3;
   localparam logic [7:0] RESERVED_BYTE = 8'h00;
   localparam logic [7:0] ATYP_IPV4     = 8'd1;
   localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
   localparam logic [7:0] ATYP_IPV6     = 8'd4;
   localparam logic [7:0] IPV4_LENGTH   = 8'd4;
   localparam logic [7:0] IPV6_LENGTH   = 8'd16;
   localparam logic [1:0] PORT_BYTES    = 2'd2;

   // parser state held between words
   typedef struct packed {
      phase_type   phase;
      logic [1:0]  command;
      logic [2:0]  address_kind;
      logic [7:0]  expected_length;
      logic [7:0]  byte_index;
      logic [1:0]  port_count;
      logic [15:0] port_value;
   } parser_state_type;

   localparam parser_state_type PARSER_RESET = '{
      phase:           PH_VER,
      command:         2'd0,
      address_kind:    3'd0,
      expected_length: 8'd0,
      byte_index:      8'd0,
      port_count:      2'd0,
      port_value:      16'd0
   };

   // one result word
   typedef struct packed {
      logic [1:0]     status;
      field_kind_type field_kind;
      logic [7:0]     address_index;
      logic [7:0]     address_byte;
      logic [1:0]     command;
      logic [2:0]     address_kind;
      logic [7:0]     address_size;
      logic [15:0]    port_number;
   } rsp_word_type;

endpackage
`default_nettype wire

// File: hw/rtl/s5rp_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s5rp_req_if
// Request channel: one stream byte and a restart flag per word.
// ----------------------------------------------------------------------------
interface s5rp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/s5rp_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s5rp_rsp_if
// Response channel: parse status and decoded fields per word.
// ----------------------------------------------------------------------------
interface s5rp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [2:0]  field_kind;
   logic [7:0]  address_index;
   logic [7:0]  address_byte;
   logic [1:0]  command;
   logic [2:0]  address_kind;
   logic [7:0]  address_size;
   logic [15:0] port_number;

   modport source (
      output valid, output status, output field_kind, output address_index,
      output address_byte, output command, output address_kind,
      output address_size, output port_number, input ready
   );
   modport sink (
      input valid, input status, input field_kind, input address_index,
      input address_byte, input command, input address_kind,
      input address_size, input port_number, output ready
   );
endinterface
`default_nettype wire

// File: hw/rtl/s5rp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s5rp_step
// Single-byte parse step: next parser state and the result word.
// ----------------------------------------------------------------------------
module s5rp_step (
   input  s5rp_pkg::parser_state_type state,
   input  logic [7:0]                 data_byte,
   input  logic                       restart,
   output s5rp_pkg::parser_state_type next_state,
   output s5rp_pkg::rsp_word_type     word
);
   import s5rp_pkg::*;

   parser_state_type cur;
   parser_state_type nxt;
   field_kind_type   kind;
   logic [7:0]       aidx;
   logic [7:0]       abyte;
   logic [7:0]       index_inc;
   logic [1:0]       count_inc;
   logic [1:0]       status;

   assign index_inc = cur.byte_index + 8'd1;
   assign count_inc = cur.port_count + 2'd1;

   // restart acts before this byte is parsed
   assign cur = restart ? PARSER_RESET : state;

   // phase transitions
   always_comb begin
      nxt   = cur;
      kind  = FK_IGN;
      aidx  = 8'd0;
      abyte = 8'd0;
      unique case (cur.phase)
         PH_VER: begin
            kind      = FK_VER;
            nxt.phase = (data_byte == SOCKS_VERSION) ? PH_CMD : PH_ERR;
         end
         PH_CMD: begin
            kind = FK_CMD;
            if (data_byte >= CMD_CONNECT && data_byte <= CMD_UDP_ASSOC) begin
               nxt.command = data_byte[1:0];
               nxt.phase   = PH_RSV;
            end else begin
               nxt.phase = PH_ERR;
            end
         end
         PH_RSV: begin
            kind      = FK_RSV;
            nxt.phase = (data_byte == RESERVED_BYTE) ? PH_ATYP : PH_ERR;
         end
         PH_ATYP: begin
            kind = FK_ATYP;
            if (data_byte == ATYP_IPV4 || data_byte == ATYP_DOMAIN ||
                data_byte == ATYP_IPV6) begin
               nxt.address_kind    = data_byte[2:0];
               nxt.expected_length = (data_byte == ATYP_IPV4) ? IPV4_LENGTH :
                                     (data_byte == ATYP_IPV6) ? IPV6_LENGTH : 8'd0;
               nxt.byte_index      = 8'd0;
               nxt.phase           = PH_ADDR;
            end else begin
               nxt.phase = PH_ERR;
            end
         end
         PH_ADDR: begin
            // a zero expected length means the domain length byte is due
            if (cur.expected_length == 8'd0) begin
               kind = FK_DLEN;
               if (data_byte == 8'd0) begin
                  nxt.phase = PH_ERR;
               end else begin
                  nxt.expected_length = data_byte;
               end
            end else begin
               kind           = FK_ADDR;
               aidx           = cur.byte_index;
               abyte          = data_byte;
               nxt.byte_index = index_inc;
               if (index_inc >= cur.expected_length) begin
                  nxt.port_count = 2'd0;
                  nxt.port_value = 16'd0;
                  nxt.phase      = PH_PORT;
               end
            end
         end
         PH_PORT: begin
            kind           = FK_PORT;
            nxt.port_value = {cur.port_value[7:0], data_byte};
            nxt.port_count = count_inc;
            if (count_inc >= PORT_BYTES) begin
               nxt.phase = PH_DONE;
            end
         end
         default: begin
            kind = FK_IGN;
         end
      endcase
   end

   // result word from the updated state
   always_comb begin
      priority if (nxt.phase == PH_DONE) begin
         status = ST_COMPLETE;
      end else if (nxt.phase == PH_ERR) begin
         status = ST_ERROR;
      end else begin
         status = ST_BUSY;
      end
   end

   assign next_state          = nxt;
   assign word.status         = status;
   assign word.field_kind     = kind;
   assign word.address_index  = aidx;
   assign word.address_byte   = abyte;
   assign word.command        = nxt.command;
   assign word.address_kind   = nxt.address_kind;
   assign word.address_size   = nxt.expected_length;
   assign word.port_number    = (status == ST_COMPLETE) ? nxt.port_value : 16'd0;

endmodule
`default_nettype wire

// File: hw/rtl/socks5_request_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// socks5_request_parser_unit
// SOCKS5 request header parser, one stream byte per word, one result each.
// ----------------------------------------------------------------------------
// Path: request accept to response valid passes the input register, then
//    the combinational parse step into the response and state registers.
// Throughput: 1 word per cycle while the response channel does not stall.
// Reset: synchronous, active high; clears both valid flags and returns the
//    parser to awaiting the version byte.
module socks5_request_parser_unit (
   input  logic            clock,
   input  logic            reset,
   s5rp_req_if.sink        req_chan,
   s5rp_rsp_if.source      rsp_chan
);
   import s5rp_pkg::*;

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_restart_ff;
   parser_state_type state_ff;
   parser_state_type state_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   rsp_word_type     out_word_ff;
   rsp_word_type     step_word;
   logic             req_accept;
   logic             advance;

   // pipeline handshake
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   // parse step
   s5rp_step u_step (
      .state      (state_ff),
      .data_byte  (in_byte_ff),
      .restart    (in_restart_ff),
      .next_state (state_in),
      .word       (step_word)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= PARSER_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff    <= req_chan.data_byte;
         in_restart_ff <= req_chan.restart;
      end
      if (advance) begin
         out_word_ff <= step_word;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = out_word_ff.status;
   assign rsp_chan.field_kind     = out_word_ff.field_kind;
   assign rsp_chan.address_index  = out_word_ff.address_index;
   assign rsp_chan.address_byte   = out_word_ff.address_byte;
   assign rsp_chan.command        = out_word_ff.command;
   assign rsp_chan.address_kind   = out_word_ff.address_kind;
   assign rsp_chan.address_size   = out_word_ff.address_size;
   assign rsp_chan.port_number    = out_word_ff.port_number;

endmodule
`default_nettype wire

// File: hw/rtl/s5rp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s5rp_checker
// Port-level checks on the parser's response channel, bound to the top.
// ----------------------------------------------------------------------------
module s5rp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_field_kind,
   input logic [7:0]  rsp_address_index,
   input logic [1:0]  rsp_command,
   input logic [2:0]  rsp_address_kind,
   input logic [7:0]  rsp_address_size,
   input logic [15:0] rsp_port_number
);
   import s5rp_pkg::*;

   // no response straight after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response stays offered
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // a complete request has command, address type and length
   a_complete_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_COMPLETE |->
         rsp_command != 2'd0 && rsp_address_kind != 3'd0 &&
         rsp_address_size != 8'd0)
      else $error("complete request without accepted fields");

   // address bytes lie within the expected length
   a_address_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_kind == FK_ADDR |->
         rsp_address_index < rsp_address_size && rsp_status != ST_ERROR)
      else $error("address index beyond expected length");

   // port shown only once complete
   a_port_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_COMPLETE |-> rsp_port_number == 16'd0)
      else $error("port shown before request complete");

endmodule

bind socks5_request_parser_unit s5rp_checker u_s5rp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_status         (rsp_chan.status),
   .rsp_field_kind     (rsp_chan.field_kind),
   .rsp_address_index  (rsp_chan.address_index),
   .rsp_command        (rsp_chan.command),
   .rsp_address_kind   (rsp_chan.address_kind),
   .rsp_address_size   (rsp_chan.address_size),
   .rsp_port_number    (rsp_chan.port_number)
);
`default_nettype wire
